// ===== sv/fbtg_pkg.sv =====
// Shared types, constants and fixed-point helpers for the FSK tone generator.
// Used by every module of the block; depends on nothing else.
package fbtg_pkg;

	localparam int SAMPLES_PER_MS = 8;
	localparam int MAX_SAMPLES    = 8;
	localparam int CNT_W          = $clog2(MAX_SAMPLES);

	localparam int STEP_W = 16;
	localparam int PER_W  = 19;
	localparam int ACC_W  = 20;
	localparam int PH_W   = 18;
	localparam int SMP_W  = 16;
	localparam int CFG_W  = 19;
	localparam int IDX_W  = 3;
	localparam int MUL_W  = 21;
	localparam int PROD_W = 2 * MUL_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int MAG_W  = 20;

	localparam int PH_MAX  = 131071;
	localparam int PH_MIN  = -131072;
	localparam int SMP_MAX = 32767;
	localparam int SMP_MIN = -32768;

	localparam int CQ_DEPTH = 2;
	localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);
	localparam int RQ_DEPTH = 2;
	localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
	localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

	localparam logic [ACC_W-1:0]          ONE_SAMPLE = ACC_W'(65536);
	localparam logic signed [PH_W-1:0]    PH_ONE     = PH_W'(65536);
	localparam logic signed [MUL_W-1:0]   CORR_TWO   = MUL_W'(131072);
	localparam logic [CNT_W-1:0]          MS_LAST    = CNT_W'(SAMPLES_PER_MS - 1);
	localparam logic [CNT_W-1:0]          BAUD_LAST  = CNT_W'(MAX_SAMPLES - 1);

	localparam logic [1:0] MODE_DATA    = 2'd0;
	localparam logic [1:0] MODE_MS      = 2'd1;
	localparam logic [1:0] MODE_RESTART = 2'd2;

	localparam logic [IDX_W-1:0] CFG_MARK_RE  = 3'd0;
	localparam logic [IDX_W-1:0] CFG_MARK_IM  = 3'd1;
	localparam logic [IDX_W-1:0] CFG_SPACE_RE = 3'd2;
	localparam logic [IDX_W-1:0] CFG_SPACE_IM = 3'd3;
	localparam logic [IDX_W-1:0] CFG_PERIOD   = 3'd4;

	typedef enum logic [1:0] {
		CMD_DATA,
		CMD_MS,
		CMD_RESTART
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic      mark;
	} cmd_t;

	typedef struct packed {
		logic signed [STEP_W-1:0] mark_re;
		logic signed [STEP_W-1:0] mark_im;
		logic signed [STEP_W-1:0] space_re;
		logic signed [STEP_W-1:0] space_im;
		logic [PER_W-1:0]         period;
	} cfg_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] sample;
		logic                    last;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROT_RE,
		ST_ROT_IM,
		ST_ROT_SUM,
		ST_SQUARE,
		ST_CORR,
		ST_SCALE,
		ST_EMIT
	} eng_state_t;

	localparam cfg_t CFG_RESET = '{
		mark_re:  STEP_W'(19261),
		mark_im:  STEP_W'(26510),
		space_re: STEP_W'(-5126),
		space_im: STEP_W'(32365),
		period:   PER_W'(436907)
	};

	// Round half up by sh bits, then saturate to the phasor range.
	function automatic logic signed [PH_W-1:0] rnd_sat_ph(
		input logic signed [SUM_W-1:0] x,
		input int unsigned             sh
	);
		logic signed [SUM_W-1:0] t;
		t = x + signed'(SUM_W'(1) << (sh - 1));
		t = t >>> sh;
		if (t > signed'(SUM_W'(PH_MAX))) begin
			return PH_W'(PH_MAX);
		end else if (t < signed'(SUM_W'(PH_MIN))) begin
			return PH_W'(PH_MIN);
		end
		return PH_W'(t);
	endfunction

	// Round the Q2.16 real part to Q1.15 and saturate to the sample range.
	function automatic logic signed [SMP_W-1:0] to_sample(input logic signed [PH_W-1:0] p);
		logic signed [PH_W:0] t;
		t = (PH_W + 1)'(p) + (PH_W + 1)'(1);
		t = t >>> 1;
		if (t > signed'((PH_W + 1)'(SMP_MAX))) begin
			return SMP_W'(SMP_MAX);
		end else if (t < signed'((PH_W + 1)'(SMP_MIN))) begin
			return SMP_W'(SMP_MIN);
		end
		return SMP_W'(t);
	endfunction

endpackage

// ===== sv/fsk_baud_tone_generator.sv =====
// Top level of the FSK tone generator: configuration registers and the
// front, engine and result queue. Depends on fbtg_pkg and the fbtg_* modules.
//
// Usage. Commands enter as queue transactions (push/full) carrying mode and
// bit_level: a data baud emits one baud of mark or space tone, a mark
// millisecond emits eight mark samples, a restart clears the baud timer and
// emits nothing, and the unused mode code is taken and dropped. Samples leave
// as queue transactions (empty/pop); last_sample marks the final sample of a
// command. Configuration writes use cfg_valid/cfg_ready (always ready) with
// cfg_index and cfg_data, and must be made only while the block is idle; the
// block itself does not enforce this. Each sample runs through the states
// ROT_RE, ROT_IM, ROT_SUM, SQUARE, CORR, SCALE and EMIT, which rotate and
// renormalize the phasor on two shared multipliers; a command holds the
// engine until its final sample is pushed. Two-entry command and result
// queues let input and output stall independently. When the receiver stops
// popping, the engine holds its finished sample and then the command queue
// fills. Reset restores the default tone steps and baud period, the unit
// phasor and a zero baud timer, and empties both queues.
module fsk_baud_tone_generator (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      push,
	input  logic [1:0]                                mode,
	input  logic                                      bit_level,
	output logic                                      full,
	output logic                                      empty,
	input  logic                                      pop,
	output logic signed [fbtg_pkg::SMP_W-1:0]         sample,
	output logic                                      last_sample,
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [fbtg_pkg::IDX_W-1:0]                cfg_index,
	input  logic [fbtg_pkg::CFG_W-1:0]                cfg_data
);
	import fbtg_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	logic cmd_valid;
	logic cmd_pop;
	logic res_full;
	logic res_push;
	res_t res;
	res_t head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MARK_RE:  cfg_q.mark_re  <= cfg_data[STEP_W-1:0];
				CFG_MARK_IM:  cfg_q.mark_im  <= cfg_data[STEP_W-1:0];
				CFG_SPACE_RE: cfg_q.space_re <= cfg_data[STEP_W-1:0];
				CFG_SPACE_IM: cfg_q.space_im <= cfg_data[STEP_W-1:0];
				CFG_PERIOD:   cfg_q.period   <= cfg_data[PER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	fbtg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.mode      (mode),
		.bit_level (bit_level),
		.full      (full),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	fbtg_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res)
	);

	fbtg_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res      (res),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.head     (head)
	);

	assign sample      = head.sample;
	assign last_sample = head.last;

endmodule

// ===== sv/fbtg_front.sv =====
// Front end of the tone generator: takes input transactions, classifies the mode
// and holds the resulting commands in a short queue. Depends on fbtg_pkg.
module fbtg_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [1:0]    mode,
	input  logic          bit_level,
	output logic          full,
	output logic          cmd_valid,
	output fbtg_pkg::cmd_t cmd,
	input  logic          cmd_pop
);
	import fbtg_pkg::*;

	cmd_t                cq_q [CQ_DEPTH];
	logic [CQ_PTR_W-1:0] wr_ptr_q;
	logic [CQ_PTR_W-1:0] rd_ptr_q;
	logic [CQ_CNT_W-1:0] cnt_q;
	logic                keep;
	cmd_t                cls;
	logic                wr_en;
	logic                rd_en;

	always_comb begin
		keep     = 1'b1;
		cls.kind = CMD_DATA;
		cls.mark = bit_level;
		case (mode)
			MODE_DATA: begin
				cls.kind = CMD_DATA;
			end
			MODE_MS: begin
				cls.kind = CMD_MS;
				cls.mark = 1'b1;
			end
			MODE_RESTART: begin
				cls.kind = CMD_RESTART;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign full      = (cnt_q == CQ_CNT_W'(CQ_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = cq_q[rd_ptr_q];
	assign wr_en     = push && !full && keep;
	assign rd_en     = cmd_pop && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + CQ_PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + CQ_PTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + CQ_CNT_W'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - CQ_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			cq_q[wr_ptr_q] <= cls;
		end
	end

endmodule

// ===== sv/fbtg_engine.sv =====
// Back end of the tone generator: rotates and renormalizes the phasor once per
// sample on two shared multipliers and runs the baud timer. Depends on fbtg_pkg.
module fbtg_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  fbtg_pkg::cfg_t cfg,
	input  logic           cmd_valid,
	input  fbtg_pkg::cmd_t cmd,
	output logic           cmd_pop,
	input  logic           res_full,
	output logic           res_push,
	output fbtg_pkg::res_t res
);
	import fbtg_pkg::*;

	eng_state_t               state_q;
	eng_state_t               state_d;
	cmd_kind_t                kind_q;
	logic                     mark_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [PH_W-1:0]   cr_q;
	logic signed [PH_W-1:0]   ci_q;
	logic [ACC_W-1:0]         acc_q;
	logic signed [PH_W-1:0]   nr_q;
	logic signed [PH_W-1:0]   ni_q;
	logic signed [MUL_W-1:0]  corr_q;
	logic signed [PROD_W-1:0] pa_q;
	logic signed [PROD_W-1:0] pb_q;

	logic signed [STEP_W-1:0] dr;
	logic signed [STEP_W-1:0] di;
	logic signed [MUL_W-1:0]  a0, a1, b0, b1;
	logic                     mul_en;
	logic signed [SUM_W-1:0]  sum_diff;
	logic signed [SUM_W-1:0]  sum_add;
	logic [SUM_W-1:0]         mag_sum;
	logic [MAG_W-1:0]         mag;
	logic signed [PH_W-1:0]   nr_fin;
	logic signed [PH_W-1:0]   ni_fin;
	logic [ACC_W-1:0]         period_eff;
	logic [ACC_W-1:0]         acc_inc;
	logic                     baud_end;
	logic                     last;

	assign dr = mark_q ? cfg.mark_re : cfg.space_re;
	assign di = mark_q ? cfg.mark_im : cfg.space_im;

	assign sum_diff = SUM_W'(pa_q) - SUM_W'(pb_q);
	assign sum_add  = SUM_W'(pa_q) + SUM_W'(pb_q);
	assign mag_sum  = unsigned'(sum_add) + SUM_W'(32768);
	assign mag      = mag_sum[16 +: MAG_W];
	assign nr_fin   = rnd_sat_ph(SUM_W'(pa_q), 16);
	assign ni_fin   = rnd_sat_ph(SUM_W'(pb_q), 16);

	assign period_eff = ({1'b0, cfg.period} < ONE_SAMPLE) ? ONE_SAMPLE : {1'b0, cfg.period};
	assign acc_inc    = acc_q + ONE_SAMPLE;
	assign baud_end   = (acc_inc > period_eff);
	assign last       = (kind_q == CMD_DATA) ? (baud_end || (cnt_q == BAUD_LAST))
	                                         : (cnt_q == MS_LAST);

	assign res.sample = to_sample(nr_fin);
	assign res.last   = last;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && (cmd.kind != CMD_RESTART)) begin
					state_d = ST_ROT_RE;
				end
			end
			ST_ROT_RE:  state_d = ST_ROT_IM;
			ST_ROT_IM:  state_d = ST_ROT_SUM;
			ST_ROT_SUM: state_d = ST_SQUARE;
			ST_SQUARE:  state_d = ST_CORR;
			ST_CORR:    state_d = ST_SCALE;
			ST_SCALE:   state_d = ST_EMIT;
			ST_EMIT: begin
				if (!res_full) begin
					state_d = last ? ST_IDLE : ST_ROT_RE;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop  = (state_q == ST_IDLE) && cmd_valid;
		res_push = (state_q == ST_EMIT) && !res_full;
		mul_en   = 1'b1;
		a0       = '0;
		a1       = '0;
		b0       = '0;
		b1       = '0;
		case (state_q)
			ST_ROT_RE: begin
				a0 = MUL_W'(cr_q);
				a1 = MUL_W'(dr);
				b0 = MUL_W'(ci_q);
				b1 = MUL_W'(di);
			end
			ST_ROT_IM: begin
				a0 = MUL_W'(cr_q);
				a1 = MUL_W'(di);
				b0 = MUL_W'(ci_q);
				b1 = MUL_W'(dr);
			end
			ST_SQUARE: begin
				a0 = MUL_W'(nr_q);
				a1 = MUL_W'(nr_q);
				b0 = MUL_W'(ni_q);
				b1 = MUL_W'(ni_q);
			end
			ST_SCALE: begin
				a0 = MUL_W'(nr_q);
				a1 = corr_q;
				b0 = MUL_W'(ni_q);
				b1 = corr_q;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= CMD_DATA;
			mark_q  <= 1'b0;
			cnt_q   <= '0;
			cr_q    <= PH_ONE;
			ci_q    <= '0;
			acc_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd_pop) begin
				kind_q <= cmd.kind;
				mark_q <= cmd.mark;
				cnt_q  <= '0;
				if (cmd.kind == CMD_RESTART) begin
					acc_q <= '0;
				end
			end
			if (res_push) begin
				cr_q  <= nr_fin;
				ci_q  <= ni_fin;
				cnt_q <= cnt_q + CNT_W'(1);
				if (kind_q == CMD_DATA) begin
					acc_q <= baud_end ? (acc_inc - period_eff) : acc_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			pa_q <= a0 * a1;
			pb_q <= b0 * b1;
		end
		if (state_q == ST_ROT_IM) begin
			nr_q <= rnd_sat_ph(sum_diff, 15);
		end
		if (state_q == ST_ROT_SUM) begin
			ni_q <= rnd_sat_ph(sum_add, 15);
		end
		if (state_q == ST_CORR) begin
			corr_q <= CORR_TWO - signed'({1'b0, mag});
		end
	end

`ifndef SYNTHESIS
	a_phasor_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!res_push |=> $stable(cr_q) && $stable(ci_q))
		else $error("phasor changed without a sample transaction");
	a_pop_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> (state_q == ST_IDLE) || (state_q == ST_ROT_RE))
		else $error("command taken outside idle");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res.last |=> (state_q == ST_IDLE))
		else $error("engine kept running after the final sample");
`endif

endmodule

// ===== sv/fbtg_outq.sv =====
// Result queue of the tone generator: holds finished samples until the
// receiver takes them. Depends on fbtg_pkg.
module fbtg_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           res_push,
	input  fbtg_pkg::res_t res,
	output logic           res_full,
	output logic           empty,
	input  logic           pop,
	output fbtg_pkg::res_t head
);
	import fbtg_pkg::*;

	res_t                rq_q [RQ_DEPTH];
	logic [RQ_PTR_W-1:0] wr_ptr_q;
	logic [RQ_PTR_W-1:0] rd_ptr_q;
	logic [RQ_CNT_W-1:0] cnt_q;
	logic                wr_en;
	logic                rd_en;

	assign res_full = (cnt_q == RQ_CNT_W'(RQ_DEPTH));
	assign empty    = (cnt_q == '0);
	assign head     = rq_q[rd_ptr_q];
	assign wr_en    = res_push && !res_full;
	assign rd_en    = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + RQ_PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + RQ_PTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + RQ_CNT_W'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - RQ_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rq_q[wr_ptr_q] <= res;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= RQ_CNT_W'(RQ_DEPTH))
		else $error("result queue count beyond its depth");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result written into a full queue");
	a_head_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(head))
		else $error("waiting result changed before its transaction");
`endif

endmodule
